>>> src/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types, codes and constants of the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // Stream payload widths
    localparam int CH_W       = 8;
    localparam int RCOL_W     = 7;
    localparam int RROW_W     = 6;
    localparam int ACT_W      = 2;
    localparam int CELL_W     = 16;
    localparam int OCOL_W     = 7;
    localparam int OROW_W     = 6;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 7;
    localparam int ATTR_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 2'd2;

    localparam logic [COLS_REG_W-1:0] COLS_RST = 8'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RST = 7'd25;
    localparam logic [ATTR_W-1:0]     ATTR_RST = 8'd7;

    // Characters and cells
    localparam logic [CH_W-1:0]   CH_NEWLINE = 8'd10;
    localparam logic [CH_W-1:0]   CH_TAB     = 8'd9;
    localparam logic [CH_W-1:0]   CH_BLANK   = 8'h20;
    localparam logic [CELL_W-1:0] CELL_RST   = 16'h0720;
    localparam int                TAB_STEP   = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

endpackage

>>> src/tccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tccs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_regs
// Configuration registers and the clamped screen size in use.
// ----------------------------------------------------------------------------
module tccs_regs
    import tccs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]           i_cfg_wdata,
    output logic [$clog2(MAX_COLS+1)-1:0]   o_ncols,
    output logic [$clog2(MAX_ROWS+1)-1:0]   o_nrows,
    output logic [ATTR_W-1:0]               o_attr
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [COLS_REG_W-1:0] r_cols;
    logic [ROWS_REG_W-1:0] r_rows;
    logic [ATTR_W-1:0]     r_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
            r_attr <= ATTR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COLUMNS:   r_cols <= COLS_REG_W'(i_cfg_wdata);
                REG_ROWS:      r_rows <= ROWS_REG_W'(i_cfg_wdata);
                REG_ATTRIBUTE: r_attr <= ATTR_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cols == '0) begin
            o_ncols = CW'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            o_ncols = CW'(MAX_COLS);
        end else begin
            o_ncols = CW'(r_cols);
        end
        if (r_rows == '0) begin
            o_nrows = RW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            o_nrows = RW'(MAX_ROWS);
        end else begin
            o_nrows = RW'(r_rows);
        end
    end

    assign o_attr = r_attr;

endmodule

>>> src/tccs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_seq
// Action sequencer: cursor, cell buffer walks and the result register.
// ----------------------------------------------------------------------------
module tccs_seq
    import tccs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_COLS+1)-1:0]          i_ncols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]          i_nrows,
    input  logic [ATTR_W-1:0]                      i_attr,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]                   s_axis_tdata,
    input  logic [ACT_W-1:0]                       s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]                  m_axis_tdata,
    output logic                                   o_ram_we,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]   o_ram_waddr,
    output logic [CELL_W-1:0]                      o_ram_wdata,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]   o_ram_raddr,
    input  logic [CELL_W-1:0]                      i_ram_rdata
);

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [10:0] {
        ST_INIT      = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_PUT       = 11'b000_0000_0100,
        ST_TAB       = 11'b000_0000_1000,
        ST_CHECK     = 11'b000_0001_0000,
        ST_SCROLL    = 11'b000_0010_0000,
        ST_SCRL_LAST = 11'b000_0100_0000,
        ST_BLANK     = 11'b000_1000_0000,
        ST_CLEAR     = 11'b001_0000_0000,
        ST_RD_WAIT   = 11'b010_0000_0000,
        ST_FINISH    = 11'b100_0000_0000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    t_state              r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic [CW-1:0]       r_cnt_col, n_cnt_col;
    logic [RW-1:0]       r_cnt_row, n_cnt_row;
    logic                r_pend_valid, n_pend_valid;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    logic [AW-1:0]       r_init_addr, n_init_addr;
    logic                r_scr, n_scr;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic                r_rd_ok, n_rd_ok;
    logic                r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    t_action             in_act;
    logic [CH_W-1:0]     in_ch;
    logic [RCOL_W-1:0]   in_rcol;
    logic [RROW_W-1:0]   in_rrow;
    logic [CW-1:0]       sat_col;
    logic [RW-1:0]       sat_row;
    logic [CW-1:0]       col_inc;
    logic [CW-1:0]       last_col;
    logic [RW-1:0]       last_row;
    logic [CELL_W-1:0]   blank_cell;

    assign in_act  = t_action'(s_axis_tuser);
    assign in_ch   = s_axis_tdata[CH_W-1:0];
    assign in_rcol = s_axis_tdata[CH_W+RCOL_W-1:CH_W];
    assign in_rrow = s_axis_tdata[CH_W+RCOL_W+RROW_W-1:CH_W+RCOL_W];

    assign last_col   = i_ncols - CW'(1);
    assign last_row   = i_nrows - RW'(1);
    assign sat_col    = (r_col >= i_ncols) ? last_col : r_col;
    assign sat_row    = (r_row >= i_nrows) ? last_row : r_row;
    assign col_inc    = r_col + CW'(1);
    assign blank_cell = {i_attr, CH_BLANK};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_ch         = r_ch;
        n_cnt_col    = r_cnt_col;
        n_cnt_row    = r_cnt_row;
        n_pend_valid = r_pend_valid;
        n_pend_addr  = r_pend_addr;
        n_init_addr  = r_init_addr;
        n_scr        = r_scr;
        n_cell       = r_cell;
        n_rd_ok      = r_rd_ok;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        o_ram_we     = 1'b0;
        o_ram_waddr  = cell_addr(r_row, r_col);
        o_ram_wdata  = blank_cell;
        o_ram_raddr  = cell_addr(r_cnt_row, r_cnt_col);

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_INIT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_init_addr;
                o_ram_wdata = CELL_RST;
                if (r_init_addr == AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_init_addr = r_init_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_scr  = 1'b0;
                    n_cell = '0;
                    case (in_act)
                        ACT_PUT: begin
                            n_col = sat_col;
                            n_row = sat_row;
                            n_ch  = in_ch;
                            if (in_ch == CH_NEWLINE) begin
                                n_col   = '0;
                                n_row   = sat_row + RW'(1);
                                n_state = ST_CHECK;
                            end else if (in_ch == CH_TAB) begin
                                n_state = ST_TAB;
                            end else begin
                                n_state = ST_PUT;
                            end
                        end
                        ACT_CLEAR: begin
                            n_cnt_col = '0;
                            n_cnt_row = '0;
                            n_state   = ST_CLEAR;
                        end
                        ACT_READ: begin
                            o_ram_raddr = AW'(int'(in_rrow) * MAX_COLS + int'(in_rcol));
                            n_rd_ok     = (int'(in_rcol) < MAX_COLS) &&
                                          (int'(in_rrow) < MAX_ROWS);
                            n_state     = ST_RD_WAIT;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = {i_attr, r_ch};
                if (col_inc >= i_ncols) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = col_inc;
                end
                n_state = ST_CHECK;
            end
            ST_TAB: begin
                o_ram_we = 1'b1;
                if (((col_inc & CW'(TAB_STEP - 1)) != '0) && (col_inc < last_col)) begin
                    n_col = col_inc;
                end else begin
                    if (col_inc >= i_ncols) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                    end else begin
                        n_col = col_inc;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_row >= i_nrows) begin
                    n_row        = last_row;
                    n_scr        = 1'b1;
                    n_cnt_col    = '0;
                    n_cnt_row    = RW'(1);
                    n_pend_valid = 1'b0;
                    n_state      = (i_nrows == RW'(1)) ? ST_BLANK : ST_SCROLL;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCROLL: begin
                // Read one row below, write back the cell read last cycle
                n_pend_valid = 1'b1;
                n_pend_addr  = cell_addr(r_cnt_row, r_cnt_col) - AW'(MAX_COLS);
                o_ram_we     = r_pend_valid;
                o_ram_waddr  = r_pend_addr;
                o_ram_wdata  = i_ram_rdata;
                if (r_cnt_col == last_col) begin
                    n_cnt_col = '0;
                    if (r_cnt_row == last_row) begin
                        n_state = ST_SCRL_LAST;
                    end else begin
                        n_cnt_row = r_cnt_row + RW'(1);
                    end
                end else begin
                    n_cnt_col = r_cnt_col + CW'(1);
                end
            end
            ST_SCRL_LAST: begin
                o_ram_we     = 1'b1;
                o_ram_waddr  = r_pend_addr;
                o_ram_wdata  = i_ram_rdata;
                n_pend_valid = 1'b0;
                n_cnt_col    = '0;
                n_state      = ST_BLANK;
            end
            ST_BLANK: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = cell_addr(last_row, r_cnt_col);
                if (r_cnt_col == last_col) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt_col = r_cnt_col + CW'(1);
                end
            end
            ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = cell_addr(r_cnt_row, r_cnt_col);
                if (r_cnt_col == last_col) begin
                    n_cnt_col = '0;
                    if (r_cnt_row == last_row) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_cnt_row = r_cnt_row + RW'(1);
                    end
                end else begin
                    n_cnt_col = r_cnt_col + CW'(1);
                end
            end
            ST_RD_WAIT: begin
                n_cell  = r_rd_ok ? i_ram_rdata : '0;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold until the result register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_scr, OROW_W'(r_row), OCOL_W'(r_col), r_cell};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_col        <= '0;
            r_row        <= '0;
            r_pend_valid <= 1'b0;
            r_init_addr  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_pend_valid <= n_pend_valid;
            r_init_addr  <= n_init_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch        <= n_ch;
        r_cnt_col   <= n_cnt_col;
        r_cnt_row   <= n_cnt_row;
        r_pend_addr <= n_pend_addr;
        r_scr       <= n_scr;
        r_cell      <= n_cell;
        r_rd_ok     <= n_rd_ok;
        r_out_data  <= n_out_data;
    end

endmodule

>>> src/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode console engine: cell buffer in one RAM, cursor, scroll and clear.
// Each action runs through its states before the result loads: a tab writes 1 to 4
//   blanks, a clear blanks rows*columns cells, and a scroll copies each row up and
//   blanks the last row (only the blanking with one row); a stall holds the result.
// Throughput: one item at a time; the next item can be accepted in the cycle after the result loads.
// Reset: a sweep over all MAX_COLS*MAX_ROWS cells fills the buffer with blanks
//   (0x0720); no item is accepted until it ends, configuration writes are.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // ch, read_col, read_row
    input  logic [ACT_W-1:0]      s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // cell_res, cursor_col, cursor_row, scrolled
);

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [CW-1:0]     ncols;
    logic [RW-1:0]     nrows;
    logic [ATTR_W-1:0] attr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tccs_regs #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ncols     (ncols),
        .o_nrows     (nrows),
        .o_attr      (attr)
    );

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tccs_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ncols       (ncols),
        .i_nrows       (nrows),
        .i_attr        (attr),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

endmodule

>>> verif/tb_text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking testbench for the text console engine. A shadow console in
// the bench tracks the cell buffer, cursor and registers. Each accepted item
// queues the expected cursor report. Every output transfer is compared field
// by field against the oldest queued report. Directed tests cover power-up
// contents, tab wrap and scroll, and out-of-range register values. They also
// cover a cursor left outside the screen after a shrink. Random sessions then
// run under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;
    import tccs_pkg::*;

    localparam int CELLS       = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 12;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [CELL_W-1:0] cell_res;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic              scrolled;
    } cursor_report_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = REG_COLUMNS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // ch, read_col, read_row
    logic [ACT_W-1:0]      s_axis_tuser  = '0;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // cell_res, cursor_col, cursor_row, scrolled

    logic [CELL_W-1:0]     shadow_cells [CELLS];
    int unsigned           shadow_row;
    int unsigned           shadow_col;
    logic [COLS_REG_W-1:0] shadow_columns;
    logic [ROWS_REG_W-1:0] shadow_rows;
    logic [ATTR_W-1:0]     shadow_attr;

    cursor_report_t        reports_due [$];
    int                    errors        = 0;
    int                    items_sent    = 0;
    int                    reads_sent    = 0;
    int                    clears_sent   = 0;
    int                    results_seen  = 0;
    int                    scrolls_seen  = 0;
    int                    settings_used = 0;
    int                    burst_left    = 0;
    bit                    long_hold_req = 1'b0;

    text_console_cursor_scroll dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned used_columns();
        if (shadow_columns == 0) return 1;
        if (shadow_columns > MAX_COLS_DEF) return MAX_COLS_DEF;
        return shadow_columns;
    endfunction

    function automatic int unsigned used_rows();
        if (shadow_rows == 0) return 1;
        if (shadow_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
        return shadow_rows;
    endfunction

    function automatic cursor_report_t advance_console(t_action act, logic [CH_W-1:0] ch,
                                                       logic [RCOL_W-1:0] rcol,
                                                       logic [RROW_W-1:0] rrow);
        int unsigned    ncols;
        int unsigned    nrows;
        int unsigned    r;
        int unsigned    c;
        bit             tab_done;
        cursor_report_t rep;
        ncols = used_columns();
        nrows = used_rows();
        rep   = '0;
        case (act)
            ACT_PUT: begin
                if (shadow_row >= nrows) shadow_row = nrows - 1;
                if (shadow_col >= ncols) shadow_col = ncols - 1;
                if (ch == CH_NEWLINE) begin
                    shadow_row++;
                    shadow_col = 0;
                end else if (ch == CH_TAB) begin
                    tab_done = 1'b0;
                    while (!tab_done) begin
                        shadow_cells[shadow_row * MAX_COLS_DEF + shadow_col] =
                            {shadow_attr, CH_BLANK};
                        shadow_col++;
                        tab_done = (shadow_col % TAB_STEP == 0) || (shadow_col + 1 >= ncols);
                    end
                end else begin
                    shadow_cells[shadow_row * MAX_COLS_DEF + shadow_col] = {shadow_attr, ch};
                    shadow_col++;
                end
                if (shadow_col >= ncols) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= nrows) begin
                    for (r = 0; r + 1 < nrows; r++)
                        for (c = 0; c < ncols; c++)
                            shadow_cells[r * MAX_COLS_DEF + c] =
                                shadow_cells[(r + 1) * MAX_COLS_DEF + c];
                    for (c = 0; c < ncols; c++)
                        shadow_cells[(nrows - 1) * MAX_COLS_DEF + c] = {shadow_attr, CH_BLANK};
                    shadow_row   = nrows - 1;
                    rep.scrolled = 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (r = 0; r < nrows; r++)
                    for (c = 0; c < ncols; c++)
                        shadow_cells[r * MAX_COLS_DEF + c] = {shadow_attr, CH_BLANK};
                shadow_row = 0;
                shadow_col = 0;
            end
            ACT_READ: begin
                rep.cell_res = shadow_cells[rrow * MAX_COLS_DEF + rcol];
            end
            default: begin
            end
        endcase
        rep.col = OCOL_W'(shadow_col);
        rep.row = OROW_W'(shadow_row);
        return rep;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    task automatic send_item(t_action act, logic [CH_W-1:0] ch,
                             logic [RCOL_W-1:0] rcol, logic [RROW_W-1:0] rrow);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= IN_DATA_W'({rrow, rcol, ch});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        reports_due.push_back(advance_console(act, ch, rcol, rrow));
        items_sent++;
        if (act == ACT_READ) reads_sent++;
        if (act == ACT_CLEAR) clears_sent++;
    endtask

    // Bursts of random length, separated by random gaps
    task automatic offer(t_action act, logic [CH_W-1:0] ch,
                         logic [RCOL_W-1:0] rcol, logic [RROW_W-1:0] rrow);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_item(act, ch, rcol, rrow);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_screen(logic [COLS_REG_W-1:0] cols, logic [ROWS_REG_W-1:0] rows,
                              logic [ATTR_W-1:0] attr);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_COLUMNS;
        i_cfg_wdata <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        i_cfg_idx   <= REG_ROWS;
        i_cfg_wdata <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        i_cfg_idx   <= REG_ATTRIBUTE;
        i_cfg_wdata <= CFG_DATA_W'(attr);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_columns = cols;
        shadow_rows    = rows;
        shadow_attr    = attr;
        settings_used++;
    endtask

    task automatic random_item(int newline_pct);
        int                pick;
        t_action           act;
        logic [CH_W-1:0]   ch;
        logic [RCOL_W-1:0] rcol;
        logic [RROW_W-1:0] rrow;
        pick = $urandom_range(0, 99);
        ch   = CH_W'($urandom_range(0, 255));
        rcol = RCOL_W'($urandom_range(0, 127));
        rrow = RROW_W'($urandom_range(0, 63));
        if (pick < 3) begin
            act = ACT_CLEAR;
        end else if (pick < 5) begin
            act = ACT_NOP;
        end else if (pick < 20) begin
            act = ACT_READ;
            if ($urandom_range(0, 1) == 1) begin
                rcol = RCOL_W'($urandom_range(0, used_columns() - 1));
                rrow = RROW_W'($urandom_range(0, used_rows() - 1));
            end
        end else begin
            act  = ACT_PUT;
            pick = $urandom_range(0, 99);
            if (pick < newline_pct) ch = CH_NEWLINE;
            else if (pick < newline_pct + 10) ch = CH_TAB;
        end
        offer(act, ch, rcol, rrow);
    endtask

    task automatic test_power_up_state();
        offer(ACT_READ, 8'h00, 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd127, 6'd63);
        offer(ACT_NOP, 8'hFF, 7'd127, 6'd63);
        offer(ACT_PUT, 8'h00, 7'd0, 6'd0);
        offer(ACT_PUT, 8'hFF, 7'd0, 6'd0);
        offer(ACT_PUT, CH_TAB, 7'd0, 6'd0);
        offer(ACT_PUT, CH_NEWLINE, 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd1, 6'd0);
    endtask

    task automatic test_tab_wrap_and_scroll();
        drain();
        set_screen(8'd5, 7'd2, 8'hA5);
        offer(ACT_PUT, "x", 7'd0, 6'd0);
        offer(ACT_PUT, CH_TAB, 7'd0, 6'd0);
        // tab from the last column wraps to the start of the next row
        offer(ACT_PUT, CH_TAB, 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd4, 6'd0);
        offer(ACT_READ, 8'h00, 7'd1, 6'd0);
        offer(ACT_PUT, CH_NEWLINE, 7'd0, 6'd0);
    endtask

    task automatic test_register_limits();
        drain();
        set_screen(8'd0, 7'd0, 8'h00);
        offer(ACT_PUT, "Q", 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd0, 6'd0);
        offer(ACT_CLEAR, 8'h00, 7'd0, 6'd0);
        drain();
        set_screen(8'hFF, 7'h7F, 8'hFF);
        offer(ACT_READ, 8'h00, 7'd127, 6'd63);
        offer(ACT_CLEAR, 8'h00, 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd127, 6'd63);
    endtask

    task automatic test_cursor_after_shrink();
        offer(ACT_PUT, CH_NEWLINE, 7'd0, 6'd0);
        offer(ACT_PUT, CH_NEWLINE, 7'd0, 6'd0);
        drain();
        set_screen(8'd3, 7'd2, 8'h3C);
        offer(ACT_READ, 8'h00, 7'd0, 6'd0);
        offer(ACT_PUT, "z", 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd0, 6'd1);
        // cells outside the shrunk screen survive a clear
        offer(ACT_CLEAR, 8'h00, 7'd0, 6'd0);
        offer(ACT_READ, 8'h00, 7'd5, 6'd5);
    endtask

    task automatic test_output_backpressure();
        drain();
        set_screen(8'd6, 7'd3, 8'($urandom_range(0, 255)));
        long_hold_req = 1'b1;
        while (long_hold_req) @(posedge i_clk);
        repeat (30) send_item(ACT_PUT, 8'($urandom_range(0, 255)), 7'd0, 6'd0);
        drain();
    endtask

    task automatic test_random_sessions();
        int s;
        int count;
        int newline_pct;
        for (s = 0; s < 14; s++) begin
            drain();
            count       = 125;
            newline_pct = 12;
            case (s)
                0: begin
                    set_screen(8'd1, 7'd1, 8'($urandom_range(0, 255)));
                    count = 60;
                end
                1: begin
                    set_screen(8'd128, 7'd64, 8'($urandom_range(0, 255)));
                    count       = 120;
                    newline_pct = 40;
                end
                2: begin
                    set_screen(8'hFF, 7'h7F, 8'($urandom_range(0, 255)));
                    count = 40;
                end
                3: begin
                    set_screen(8'd1, 7'd64, 8'($urandom_range(0, 255)));
                    count = 80;
                end
                4: begin
                    set_screen(8'd128, 7'd1, 8'($urandom_range(0, 255)));
                    count = 80;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_screen(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                                   8'($urandom_range(0, 255)));
                    else
                        set_screen(8'($urandom_range(1, 20)), 7'($urandom_range(1, 8)),
                                   8'($urandom_range(0, 255)));
                end
            endcase
            repeat (count) random_item(newline_pct);
        end
    endtask

    initial begin : rx_pattern
        int n;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            n = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
            n = $urandom_range(0, 6);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        cursor_report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (reports_due.size() == 0) begin
                report_mismatch("transfer with nothing expected", m_axis_tdata, 32'd0);
            end else begin
                want = reports_due.pop_front();
                if (m_axis_tdata[CELL_W-1:0] !== want.cell_res)
                    report_mismatch("cell_res", m_axis_tdata[CELL_W-1:0], want.cell_res);
                if (m_axis_tdata[CELL_W +: OCOL_W] !== want.col)
                    report_mismatch("cursor_col", m_axis_tdata[CELL_W +: OCOL_W], want.col);
                if (m_axis_tdata[CELL_W+OCOL_W +: OROW_W] !== want.row)
                    report_mismatch("cursor_row", m_axis_tdata[CELL_W+OCOL_W +: OROW_W],
                                    want.row);
                if (m_axis_tdata[CELL_W+OCOL_W+OROW_W] !== want.scrolled)
                    report_mismatch("scrolled", m_axis_tdata[CELL_W+OCOL_W+OROW_W],
                                    want.scrolled);
                if (want.scrolled) scrolls_seen++;
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < CELLS; k++) shadow_cells[k] = CELL_RST;
        shadow_row     = 0;
        shadow_col     = 0;
        shadow_columns = COLS_RST;
        shadow_rows    = ROWS_RST;
        shadow_attr    = ATTR_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_up_state();
        test_tab_wrap_and_scroll();
        test_register_limits();
        test_cursor_after_shrink();
        test_output_backpressure();
        test_random_sessions();
        drain();
        $display("Covered %0d items (%0d reads, %0d clears) and %0d results, %0d with scroll.",
                 items_sent, reads_sent, clears_sent, results_seen, scrolls_seen);
        $display("Used %0d screen settings incl. zero and oversize limits, %0d-cycle output hold.",
                 settings_used, LONG_HOLD);
        if (errors == 0 && reports_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(120_000_000);
        $display("Timeout with %0d results still pending.", reports_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/tccs_pkg.sv
src/tccs_ram.sv
src/tccs_regs.sv
src/tccs_seq.sv
src/text_console_cursor_scroll.sv
verif/tb_text_console_cursor_scroll.sv
